// File: src/plfs_pkg.sv
`default_nettype none

package plfs_pkg;

    localparam int POS_W   = 12;
    localparam int SPEED_W = 8;
    localparam int ERR_W   = 13;
    localparam int DERIV_W = 14;
    localparam int D9_W    = 18;
    localparam int SUM_W   = 32;
    localparam int QP_W    = 9;
    localparam int QI_W    = 19;
    localparam int QD_W    = 14;
    localparam int CORR_W  = 21;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 1'd1;

    localparam logic [POS_W-1:0]   SETPOINT_RESET  = 12'd2000;
    localparam logic [SPEED_W-1:0] MAX_SPEED_RESET = 8'd255;

    localparam logic [SUM_W-1:0] SUM_MAX = 32'h7FFF_FFFF;
    localparam logic [SUM_W-1:0] SUM_MIN = 32'h8000_0000;

    // Reciprocals for truncating division of magnitudes.
    // x/10   = (x * 6554) >> 16           exact for x < 2^14
    // x/5    = (x * 209716) >> 20         exact for x < 2^17 (x = 9*deriv)
    // x/6000 = ((x >> 4) * 366503876) >> 37, exact for x <= 2^31
    localparam logic [12:0] P_RECIP = 13'd6554;
    localparam int          P_SHIFT = 16;
    localparam logic [17:0] D_RECIP = 18'd209716;
    localparam int          D_SHIFT = 20;
    localparam logic [28:0] I_RECIP = 29'd366503876;
    localparam int          I_SHIFT = 37;

    // error stage -> divide stage
    typedef struct packed {
        logic [ERR_W-1:0] err;
        logic [D9_W-1:0]  d9;
        logic [SUM_W-1:0] sum;
    } err_item_t;

    // divide stage -> mix stage (quotient magnitudes and signs)
    typedef struct packed {
        logic            p_neg;
        logic [QP_W-1:0] qp;
        logic            i_neg;
        logic [QI_W-1:0] qi;
        logic            d_neg;
        logic [QD_W-1:0] qd;
    } quot_item_t;

endpackage

`default_nettype wire

// File: src/plfs_if.sv
`default_nettype none

interface plfs_sample_if import plfs_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] position;

    modport source (output valid, output position, input ready);
    modport sink   (input valid, input position, output ready);
endinterface

interface plfs_speed_if import plfs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [SPEED_W-1:0] left_speed;
    logic [SPEED_W-1:0] right_speed;

    modport source (output valid, output left_speed, output right_speed, input ready);
    modport sink   (input valid, input left_speed, input right_speed, output ready);
endinterface

`default_nettype wire

// File: src/plfs_err_stage.sv
`default_nettype none

module plfs_err_stage import plfs_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    plfs_sample_if.sink           sample,
    input  wire logic [POS_W-1:0] setpoint,
    input  wire logic             down_ready,
    output logic                  item_valid,
    output err_item_t             item
);

    logic             s1_valid_reg;
    logic [POS_W-1:0] pos_reg;
    logic             s2_valid_reg;
    err_item_t        item_reg;
    logic [ERR_W-1:0] prev_err_reg;
    logic [SUM_W-1:0] sum_reg;

    logic             s2_ready;
    logic             s1_ready;
    logic             advance;
    logic [ERR_W-1:0]   err;
    logic [DERIV_W-1:0] deriv;
    logic [D9_W-1:0]    d9;
    logic [SUM_W:0]     sum_wide;
    logic [SUM_W-1:0]   sum_next;

    assign s2_ready = !s2_valid_reg || down_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign sample.ready = s1_ready;
    assign advance = s1_valid_reg && s2_ready;

    // error always fits 13 signed bits
    assign err   = {1'b0, pos_reg} - {1'b0, setpoint};
    assign deriv = {err[ERR_W-1], err} - {prev_err_reg[ERR_W-1], prev_err_reg};
    assign d9    = {deriv[DERIV_W-1], deriv, 3'b000}
                 + {{(D9_W-DERIV_W){deriv[DERIV_W-1]}}, deriv};

    assign sum_wide = {sum_reg[SUM_W-1], sum_reg}
                    + {{(SUM_W+1-ERR_W){err[ERR_W-1]}}, err};

    always_comb
    begin
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
        begin
            sum_next = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            sum_next = sum_wide[SUM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            prev_err_reg <= '0;
            sum_reg      <= '0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= sample.valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (advance)
            begin
                prev_err_reg <= err;
                sum_reg      <= sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && sample.valid)
        begin
            pos_reg <= sample.position;
        end
        if (advance)
        begin
            item_reg.err <= err;
            item_reg.d9  <= d9;
            item_reg.sum <= sum_next;
        end
    end

    assign item_valid = s2_valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// File: src/plfs_div_stage.sv
`default_nettype none

module plfs_div_stage import plfs_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      up_valid,
    input  wire err_item_t up_item,
    output logic           up_ready,
    input  wire logic      down_ready,
    output logic           item_valid,
    output quot_item_t     item
);

    logic       valid_reg;
    quot_item_t item_reg;
    quot_item_t item_next;

    logic [ERR_W-1:0] err_abs;
    logic [D9_W-1:0]  d9_abs;
    logic [SUM_W-1:0] sum_abs;
    logic [24:0]      p_prod;
    logic [34:0]      d_prod;
    logic [56:0]      i_prod;

    assign up_ready = !valid_reg || down_ready;

    assign err_abs = up_item.err[ERR_W-1] ? (~up_item.err + 1'b1) : up_item.err;
    assign d9_abs  = up_item.d9[D9_W-1]   ? (~up_item.d9 + 1'b1)  : up_item.d9;
    assign sum_abs = up_item.sum[SUM_W-1] ? (~up_item.sum + 1'b1) : up_item.sum;

    assign p_prod = {13'b0, err_abs[ERR_W-2:0]} * {12'b0, P_RECIP};
    assign d_prod = {18'b0, d9_abs[D9_W-2:0]} * {17'b0, D_RECIP};
    assign i_prod = {29'b0, sum_abs[SUM_W-1:4]} * {28'b0, I_RECIP};

    always_comb
    begin
        item_next.p_neg = up_item.err[ERR_W-1];
        item_next.qp    = p_prod[P_SHIFT +: QP_W];
        item_next.d_neg = up_item.d9[D9_W-1];
        item_next.qd    = d_prod[D_SHIFT +: QD_W];
        item_next.i_neg = up_item.sum[SUM_W-1];
        item_next.qi    = i_prod[I_SHIFT +: QI_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// File: src/plfs_mix_stage.sv
`default_nettype none

module plfs_mix_stage import plfs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               up_valid,
    input  wire quot_item_t         up_item,
    output logic                    up_ready,
    input  wire logic [SPEED_W-1:0] max_speed,
    plfs_speed_if.source            speed
);

    logic               valid_reg;
    logic [SPEED_W-1:0] left_reg;
    logic [SPEED_W-1:0] right_reg;
    logic [SPEED_W-1:0] left_next;
    logic [SPEED_W-1:0] right_next;

    logic signed [CORR_W-1:0] tp;
    logic signed [CORR_W-1:0] ti;
    logic signed [CORR_W-1:0] td;
    logic signed [CORR_W-1:0] corr;
    logic signed [CORR_W-1:0] lim;
    logic signed [CORR_W-1:0] corr_clamped;
    logic signed [CORR_W-1:0] left_wide;
    logic signed [CORR_W-1:0] right_wide;

    assign up_ready = !valid_reg || speed.ready;

    always_comb
    begin
        tp = $signed({{(CORR_W-QP_W){1'b0}}, up_item.qp});
        ti = $signed({{(CORR_W-QI_W){1'b0}}, up_item.qi});
        td = $signed({{(CORR_W-QD_W){1'b0}}, up_item.qd});
        if (up_item.p_neg)
        begin
            tp = -tp;
        end
        if (up_item.i_neg)
        begin
            ti = -ti;
        end
        if (up_item.d_neg)
        begin
            td = -td;
        end
        corr = tp + ti + td;
        lim  = $signed({{(CORR_W-SPEED_W){1'b0}}, max_speed});

        if (corr > lim)
        begin
            corr_clamped = lim;
        end
        else if (corr < -lim)
        begin
            corr_clamped = -lim;
        end
        else
        begin
            corr_clamped = corr;
        end

        // negative correction slows the left wheel, otherwise the right one
        if (corr_clamped < 0)
        begin
            left_wide  = lim + corr_clamped;
            right_wide = lim;
        end
        else
        begin
            left_wide  = lim;
            right_wide = lim - corr_clamped;
        end
        left_next  = left_wide[SPEED_W-1:0];
        right_next = right_wide[SPEED_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            left_reg  <= left_next;
            right_reg <= right_next;
        end
    end

    assign speed.valid       = valid_reg;
    assign speed.left_speed  = left_reg;
    assign speed.right_speed = right_reg;

endmodule

`default_nettype wire

// File: src/pid_line_follow_steering.sv
`default_nettype none

// PID steering for a differential-drive line follower. Each item on
// "sample" is a line position (nominally 0..4000); each produces exactly one
// item on "speed" with the left and right wheel drives. The correction is
// err/10 + integral/6000 + 9*deriv/5 (each term truncated toward zero),
// clamped to +/-max_speed; a negative correction slows the left wheel,
// otherwise the right wheel slows. The integral saturates at the signed
// 32-bit limits. The pipeline is four registered stages (input register,
// error/integral update, constant dividers, mix/clamp output register), and
// a new item is accepted every cycle while the output is not stalled;
// throughput is set by the error/integral update, which closes the only
// feedback loop. Each stage keeps its own valid bit, so bubbles are
// squeezed out on an output stall.
// Configuration (setpoint at index 0, max_speed at index 1) is written via
// cfg_we/cfg_index/cfg_data and must only change while the block is idle.
// Reset values: setpoint 2000, max_speed 255, integral and previous error 0.

module pid_line_follow_steering import plfs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    plfs_sample_if.sink                sample,
    plfs_speed_if.source               speed,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [POS_W-1:0]   setpoint_reg;
    logic [SPEED_W-1:0] max_speed_reg;

    // stage 2 -> 3 and 3 -> 4 links
    logic       err_valid;
    err_item_t  err_item;
    logic       div_ready;
    logic       quot_valid;
    quot_item_t quot_item;
    logic       mix_ready;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg  <= SETPOINT_RESET;
            max_speed_reg <= MAX_SPEED_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SETPOINT:  setpoint_reg  <= cfg_data[POS_W-1:0];
                REG_MAX_SPEED: max_speed_reg <= cfg_data[SPEED_W-1:0];
                default:       ;
            endcase
        end
    end

    // input register + error, derivative, saturating integral
    plfs_err_stage u_err (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample),
        .setpoint   (setpoint_reg),
        .down_ready (div_ready),
        .item_valid (err_valid),
        .item       (err_item)
    );

    // three truncating divisions by reciprocal multiply
    plfs_div_stage u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (err_valid),
        .up_item    (err_item),
        .up_ready   (div_ready),
        .down_ready (mix_ready),
        .item_valid (quot_valid),
        .item       (quot_item)
    );

    // sum, clamp, wheel split, output register
    plfs_mix_stage u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (quot_valid),
        .up_item   (quot_item),
        .up_ready  (mix_ready),
        .max_speed (max_speed_reg),
        .speed     (speed)
    );

`ifndef SYNTH
    // only one wheel is ever slowed
    assert property (@(posedge clk) disable iff (!rst_n)
        speed.valid |-> (speed.left_speed == max_speed_reg
                         || speed.right_speed == max_speed_reg))
        else $error("both wheels below max_speed");

    // input side only backs up when every stage is full and output stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        !sample.ready |-> (speed.valid && !speed.ready))
        else $error("input stalled with room in the pipeline");

    // zero max_speed forces both wheels to zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (speed.valid && max_speed_reg == '0)
            |-> (speed.left_speed == '0 && speed.right_speed == '0))
        else $error("nonzero speed with zero max_speed");
`endif

endmodule

`default_nettype wire

// File: tb/pid_line_follow_steering_test.sv
`timescale 1ns / 1ps

module pid_line_follow_steering_test import plfs_pkg::*;;

    // PID gains as integer ratios
    localparam longint P_DIV = 10;
    localparam longint I_DIV = 6000;
    localparam longint D_MUL = 9;
    localparam longint D_DIV = 5;

    // integral saturation limits
    localparam longint SUM_HI = 64'sd2147483647;
    localparam longint SUM_LO = -64'sd2147483648;

    localparam int MAX_REPORTS   = 40;        // cap on mismatch lines
    localparam int SETTLE_CYCLES = 8;         // 4-stage pipeline plus margin
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 125;
    localparam int WALK_STEP     = 200;       // max line drift per item
    localparam int TAIL_ITEMS    = 20;
    localparam longint TIMEOUT_NS = 20_000_000;

    typedef struct packed {
        logic [SPEED_W-1:0] left;
        logic [SPEED_W-1:0] right;
    } wheel_speeds_t;

    // Steering predictor plus the in-order queue of wheel speeds it has
    // promised. One item in always gives one item out.
    class steering_scoreboard;
        logic [POS_W-1:0]   setpoint;
        logic [SPEED_W-1:0] max_speed;
        longint             prev_err;
        int                 err_sum;
        wheel_speeds_t      expected_speeds[$];
        int                 failures;
        int                 reported;

        function new();
            setpoint  = SETPOINT_RESET;
            max_speed = MAX_SPEED_RESET;
            prev_err  = 0;
            err_sum   = 0;
            failures  = 0;
            reported  = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_SETPOINT)
                setpoint = data;
            else if (idx == REG_MAX_SPEED)
                max_speed = data[SPEED_W-1:0];
        endfunction

        function void note_position(logic [POS_W-1:0] pos);
            longint        pos_v;
            longint        sp_v;
            longint        err;
            longint        deriv;
            longint        total;
            longint        lim;
            longint        corr;
            longint        sum_v;
            wheel_speeds_t w;
            pos_v = pos;
            sp_v  = setpoint;
            lim   = max_speed;
            err   = pos_v - sp_v;
            deriv = err - prev_err;
            // integral clips at the 32-bit limits instead of wrapping
            total = longint'(err_sum) + err;
            if (total > SUM_HI)
                total = SUM_HI;
            if (total < SUM_LO)
                total = SUM_LO;
            err_sum  = int'(total);
            prev_err = err;
            sum_v    = err_sum;
            // longint division truncates toward zero
            corr = err / P_DIV + sum_v / I_DIV + (deriv * D_MUL) / D_DIV;
            if (corr > lim)
                corr = lim;
            if (corr < -lim)
                corr = -lim;
            if (corr < 0)
            begin
                w.left  = SPEED_W'(lim + corr);
                w.right = SPEED_W'(lim);
            end
            else
            begin
                w.left  = SPEED_W'(lim);
                w.right = SPEED_W'(lim - corr);
            end
            expected_speeds.push_back(w);
        endfunction

        function void check_speeds(logic [SPEED_W-1:0] left, logic [SPEED_W-1:0] right);
            wheel_speeds_t w;
            if (expected_speeds.size() == 0)
            begin
                failures++;
                if (reported++ < MAX_REPORTS)
                    $display("%0t: unexpected speed item left=%0d right=%0d",
                             $time, left, right);
                return;
            end
            w = expected_speeds.pop_front();
            if (left !== w.left)
            begin
                failures++;
                if (reported++ < MAX_REPORTS)
                    $display("%0t: left_speed expected %0d actual %0d",
                             $time, w.left, left);
            end
            if (right !== w.right)
            begin
                failures++;
                if (reported++ < MAX_REPORTS)
                    $display("%0t: right_speed expected %0d actual %0d",
                             $time, w.right, right);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    plfs_sample_if sample_ch ();
    plfs_speed_if  speed_ch ();

    steering_scoreboard steer_sb;

    // idling controls: steady flags switch off gaps / stalls for a stretch
    bit src_steady;
    bit sink_steady;
    int src_burst_left;
    bit sink_open;
    int sink_run;

    logic [POS_W-1:0] pos_plan[$];

    pid_line_follow_steering DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch),
        .speed     (speed_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Receiver: alternating open/closed runs of random length, or always
    // open while sink_steady is set.
    always @(negedge clk)
    begin
        if (sink_run == 0)
        begin
            sink_open = !sink_open;
            sink_run  = sink_open ? $urandom_range(1, 12) : $urandom_range(1, 5);
        end
        sink_run--;
        speed_ch.ready <= sink_steady || sink_open;
    end

    // Result monitor: values seen at the edge are the pre-update ones.
    always @(posedge clk)
    begin
        if (rst_n && speed_ch.valid && speed_ch.ready)
            steer_sb.check_speeds(speed_ch.left_speed, speed_ch.right_speed);
    end

    // Offer one position, hold until taken, then maybe open a gap
    // once the current burst is used up.
    task automatic push_position(input logic [POS_W-1:0] pos);
        int gap;
        @(negedge clk);
        sample_ch.valid    <= 1'b1;
        sample_ch.position <= pos;
        do @(posedge clk); while (!sample_ch.ready);
        steer_sb.note_position(pos);
        if (!src_steady)
        begin
            if (src_burst_left == 0)
            begin
                gap            = $urandom_range(0, 6);
                src_burst_left = $urandom_range(1, 16);
                if (gap > 0)
                begin
                    @(negedge clk);
                    sample_ch.valid <= 1'b0;
                    repeat (gap - 1) @(posedge clk);
                end
            end
            else
                src_burst_left--;
        end
    endtask

    task automatic end_burst();
        @(negedge clk);
        sample_ch.valid <= 1'b0;
    endtask

    task automatic run_plan();
        foreach (pos_plan[i])
            push_position(pos_plan[i]);
        end_burst();
    endtask

    // Let every promised item come out, then let the pipe go empty.
    task automatic wait_quiet();
        while (steer_sb.expected_speeds.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        steer_sb.set_reg(idx, data);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_gains(input logic [CFG_DATA_W-1:0] sp_data,
                             input logic [CFG_DATA_W-1:0] ms_data);
        write_reg(REG_SETPOINT, sp_data);
        write_reg(REG_MAX_SPEED, ms_data);
    endtask

    // hard stop in case the handshake hangs
    initial
    begin
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : main_seq
        int track;
        int pick;
        int step;
        logic [CFG_DATA_W-1:0] sp_data;
        logic [SPEED_W-1:0]    ms_val;

        clk                = 1'b0;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        sample_ch.valid    = 1'b0;
        sample_ch.position = '0;
        speed_ch.ready     = 1'b0;
        src_steady         = 1'b0;
        sink_steady        = 1'b0;
        src_burst_left     = 0;
        sink_open          = 1'b0;
        sink_run           = 0;
        steer_sb           = new();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // --- directed ---
        // Reset gains: on-line, both extremes, beyond-range reading,
        // full-swing derivative, alternating bit patterns, tiny errors.
        pos_plan = '{12'd2000, 12'd2000, 12'd0, 12'd4000, 12'hFFF, 12'd0,
                     12'hFFF, 12'd2001, 12'd1999, 12'hAAA, 12'h555};
        run_plan();
        wait_quiet();

        // Zero max_speed: everything clamps to 0, upper data bits dropped.
        set_gains(12'd0, 12'hF00);
        pos_plan = '{12'hFFF, 12'd0, 12'd2048};
        run_plan();
        wait_quiet();

        // Setpoint above the nominal range, clamp limit of 1.
        set_gains(12'hFFF, 12'h001);
        pos_plan = '{12'd0, 12'hFFF, 12'hFFF};
        run_plan();
        wait_quiet();

        set_gains(12'd4000, 12'h0FF);
        pos_plan = '{12'd4000, 12'd0, 12'hFFF};
        run_plan();
        wait_quiet();

        set_gains(12'd2000, 12'hA80);
        pos_plan = '{12'd3000, 12'd1000, 12'd2000};
        run_plan();
        wait_quiet();

        // --- random phases ---
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case ($urandom_range(0, 5))
                0: sp_data = 12'd0;
                1: sp_data = 12'd4000;
                2: sp_data = 12'hFFF;
                3: sp_data = 12'd2000;
                4: sp_data = CFG_DATA_W'($urandom_range(0, 4000));
                default: sp_data = CFG_DATA_W'($urandom);
            endcase
            case ($urandom_range(0, 4))
                0: ms_val = 8'd0;
                1: ms_val = 8'd1;
                2: ms_val = 8'd255;
                default: ms_val = SPEED_W'($urandom);
            endcase
            set_gains(sp_data, {4'($urandom), ms_val});

            // one phase in three runs the source, another the sink, without idling
            src_steady  = (ph % 3 == 1);
            sink_steady = (ph % 3 == 2);

            track = (sp_data > 12'd4000) ? 4000 : int'(sp_data);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                begin
                    // robot wandering around the line
                    step  = int'($urandom_range(0, 2 * WALK_STEP)) - WALK_STEP;
                    track = track + step;
                    if (track < 0)
                        track = 0;
                    if (track > 4000)
                        track = 4000;
                    push_position(POS_W'(track));
                end
                else if (pick < 75)
                begin
                    case ($urandom_range(0, 3))
                        0: push_position(12'd0);
                        1: push_position(12'd4000);
                        2: push_position(12'hFFF);
                        default: push_position(steer_sb.setpoint);
                    endcase
                end
                else
                    push_position(POS_W'($urandom));
            end
            end_burst();
            wait_quiet();
        end

        // --- integral soak ---
        // Drive maximum positive error flat out to build up the integral,
        // then pull back off it.
        src_steady  = 1'b1;
        sink_steady = 1'b1;
        set_gains(12'd0, 12'h0FF);
        for (int n = 0; n < TAIL_ITEMS; n++)
            push_position(12'hFFF);
        end_burst();
        wait_quiet();

        src_steady  = 1'b0;
        sink_steady = 1'b0;
        set_gains(12'hFFF, 12'h0FF);
        for (int n = 0; n < TAIL_ITEMS; n++)
            push_position(($urandom_range(0, 1) != 0) ? 12'd0 : POS_W'($urandom));
        end_burst();
        wait_quiet();

        if (steer_sb.failures == 0 && steer_sb.expected_speeds.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: pid_line_follow_steering.f
src/plfs_pkg.sv
src/plfs_if.sv
src/plfs_err_stage.sv
src/plfs_div_stage.sv
src/plfs_mix_stage.sv
src/pid_line_follow_steering.sv
tb/pid_line_follow_steering_test.sv
